FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the charge regulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dpcr_pkg.sv
// ----------------------------------------------------------------------------
// dpcr_pkg
// Widths, constants, register codes and controller/datapath interface types
// for the dual PWM charge regulator.
// ----------------------------------------------------------------------------
package dpcr_pkg;

   // Drive level range and loop timing
   localparam int PWM_TOP           = 254;
   localparam int LOOP_PERIOD       = 100;
   localparam int POWER_CHECK_EVERY = 10;

   localparam int LVL_W   = 8;
   localparam int PHASE_W = 7;
   localparam int C10_W   = (POWER_CHECK_EVERY > 1) ? $clog2(POWER_CHECK_EVERY) : 1;
   localparam int C3_W    = 2;

   // Field widths
   localparam int KIND_W = 2;
   localparam int MODE_W = 2;
   localparam int CUR_W  = 12;
   localparam int MV_W   = 14;
   localparam int PWR_W  = 16;

   // Stream and register port widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   // Regulation modes
   localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VOLTAGE = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_CURRENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VOLTAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CURRENT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER_REG  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER_TR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEADROOM   = 3'd6;

   // Regulator scaling
   localparam int NEARLY_OPEN_LEVEL = 60;
   localparam int REG_SPAN_MV       = 10000;
   localparam int REG_REF_MV        = 1250;
   localparam int REG_HIGHEST_MV    = REG_SPAN_MV + REG_REF_MV;
   localparam int START_DIV         = 2 * REG_HIGHEST_MV;
   localparam int POWER_SCALE       = 1000;

   // Shared multiplier and constant divide by reciprocal
   localparam int MUL_A_W     = 26;
   localparam int MUL_B_W     = 16;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int XDIV_W      = 15;
   localparam int DIV_SHIFT   = 25;
   localparam int START_RECIP = (1 << DIV_SHIFT) / START_DIV;
   localparam int END_RECIP   = (1 << DIV_SHIFT) / REG_SPAN_MV;
   localparam int QUO_W       = 11;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CUR_W-1:0]  target_current_ma;
      logic [MV_W-1:0]   target_voltage_mv;
      logic [CUR_W-1:0]  max_current_ma;
      logic [PWR_W-1:0]  max_power_regulator_mw;
      logic [PWR_W-1:0]  max_power_transistor_mw;
      logic [MV_W-1:0]   min_headroom_mv;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:                    2'd0,
      target_current_ma:       12'd0,
      target_voltage_mv:       14'd0,
      max_current_ma:          12'd1500,
      max_power_regulator_mw:  16'd11000,
      max_power_transistor_mw: 16'd20000,
      min_headroom_mv:         14'd400
   };

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ER,
      MUL_ET,
      MUL_PA,
      MUL_PB,
      MUL_Y,
      MUL_Z,
      MUL_R
   } mul_op_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_PHASE,
      STEP_OVR_REG,
      STEP_OVR_TR,
      STEP_BAL_UP,
      STEP_BAL_DN,
      STEP_OVERCUR,
      STEP_STAB,
      STEP_HEAD,
      STEP_NUDGE_UP,
      STEP_NUDGE_DN,
      STEP_FIX,
      STEP_PRESET
   } step_type;

   typedef enum logic {
      OUT_LEVELS,
      OUT_PARK
   } out_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        div_end;
      mul_op_type  mul_op;
      step_type    step;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic bal_due;
   } status_type;

endpackage

FILE: rtl/dpcr_csr.sv
// ----------------------------------------------------------------------------
// dpcr_csr
// Configuration register bank behind the register port.
// ----------------------------------------------------------------------------
module dpcr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dpcr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dpcr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dpcr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output dpcr_pkg::cfg_type                cfg
);

   dpcr_pkg::cfg_type                  cfg_ff;
   logic [dpcr_pkg::CSR_IDX_W-1:0]     idx;
   logic                               wr_en;

   assign idx        = csr_paddr[dpcr_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dpcr_pkg::CFG_RESET;
      end else if (wr_en) begin
         case (idx)
            dpcr_pkg::CSR_MODE:
               cfg_ff.mode <= csr_pwdata[dpcr_pkg::MODE_W-1:0];
            dpcr_pkg::CSR_TARGET_CURRENT:
               cfg_ff.target_current_ma <= csr_pwdata[dpcr_pkg::CUR_W-1:0];
            dpcr_pkg::CSR_TARGET_VOLTAGE:
               cfg_ff.target_voltage_mv <= csr_pwdata[dpcr_pkg::MV_W-1:0];
            dpcr_pkg::CSR_MAX_CURRENT:
               cfg_ff.max_current_ma <= csr_pwdata[dpcr_pkg::CUR_W-1:0];
            dpcr_pkg::CSR_MAX_POWER_REG:
               cfg_ff.max_power_regulator_mw <= csr_pwdata[dpcr_pkg::PWR_W-1:0];
            dpcr_pkg::CSR_MAX_POWER_TR:
               cfg_ff.max_power_transistor_mw <= csr_pwdata[dpcr_pkg::PWR_W-1:0];
            dpcr_pkg::CSR_MIN_HEADROOM:
               cfg_ff.min_headroom_mv <= csr_pwdata[dpcr_pkg::MV_W-1:0];
            default: begin
               // drop writes past the last register
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         dpcr_pkg::CSR_MODE:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.mode);
         dpcr_pkg::CSR_TARGET_CURRENT:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.target_current_ma);
         dpcr_pkg::CSR_TARGET_VOLTAGE:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.target_voltage_mv);
         dpcr_pkg::CSR_MAX_CURRENT:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.max_current_ma);
         dpcr_pkg::CSR_MAX_POWER_REG:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.max_power_regulator_mw);
         dpcr_pkg::CSR_MAX_POWER_TR:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.max_power_transistor_mw);
         dpcr_pkg::CSR_MIN_HEADROOM:
            csr_prdata = dpcr_pkg::CSR_DATA_W'(cfg_ff.min_headroom_mv);
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/dpcr_datapath.sv
// ----------------------------------------------------------------------------
// dpcr_datapath
// Sample registers, shared multiplier, saturating level adjust unit, phase
// counters and result register of the charge regulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpcr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dpcr_pkg::cfg_type                 cfg,
   input  dpcr_pkg::cmd_type                 cmd,
   output dpcr_pkg::status_type              status,
   input  logic [dpcr_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic [dpcr_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int LW  = dpcr_pkg::LVL_W;
   localparam int AW  = dpcr_pkg::MUL_A_W;
   localparam int BW  = dpcr_pkg::MUL_B_W;
   localparam int PW  = dpcr_pkg::MUL_P_W;
   localparam int CW  = PW + 2;
   localparam int MW  = dpcr_pkg::MV_W;
   localparam int IW  = dpcr_pkg::CUR_W;
   localparam int QW  = dpcr_pkg::QUO_W;
   localparam int XW  = dpcr_pkg::XDIV_W;

   localparam logic signed [3:0] D_ONE  = 4'sd1;
   localparam logic signed [3:0] D_TWO  = 4'sd2;
   localparam logic signed [3:0] D_FOUR = 4'sd4;

   function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] lvl,
                                             input logic signed [3:0] d);
      logic signed [LW+1:0] t;
      t = $signed({2'b00, lvl}) + (LW+2)'(d);
      if (t < 0)
         return '0;
      else if (t > $signed((LW+2)'(dpcr_pkg::PWM_TOP)))
         return LW'(dpcr_pkg::PWM_TOP);
      else
         return t[LW-1:0];
   endfunction

   // sample registers
   logic [IW-1:0] cur_ff;
   logic [MW-1:0] bat_ff;
   logic [MW-1:0] vr_ff;
   logic [MW-1:0] vt_ff;
   logic [MW-1:0] vres_ff;

   // products and quotient
   logic [AW-1:0] er_ff;
   logic [AW-1:0] et_ff;
   logic [PW-1:0] pa_ff;
   logic [PW-1:0] pb_ff;
   logic [QW-1:0] quo_ff;
   logic          div_end_ff;
   logic          neg_ff;
   logic          stab_ff;
   logic [dpcr_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // control state
   logic [LW-1:0]                  tr_lvl_ff, tr_lvl_in;
   logic [LW-1:0]                  reg_lvl_ff, reg_lvl_in;
   logic [dpcr_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [dpcr_pkg::C10_W-1:0]     c10_ff, c10_in;
   logic [dpcr_pkg::C3_W-1:0]      c3_ff, c3_in;

   logic [AW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] prod;
   logic [XW-1:0] x_div;
   logic [BW-1:0] divisor;
   logic [AW-1:0] rem;
   logic          fix_up;

   logic [AW-1:0] reg_lim;
   logic [AW-1:0] tr_lim;
   logic [CW-1:0] pa2, pa3, pb2, pb3;
   logic          stab_c;
   logic          nudge_up_c;
   logic          nudge_dn_c;
   logic          to_reg;
   logic [LW-1:0] park;
   logic [LW-1:0] preset_lvl;

   // ---------------------------------------------------------------- multiply
   always_comb begin
      if (cmd.div_end) begin
         if (bat_ff >= MW'(dpcr_pkg::REG_REF_MV))
            x_div = XW'(bat_ff - MW'(dpcr_pkg::REG_REF_MV));
         else
            x_div = XW'(MW'(dpcr_pkg::REG_REF_MV) - bat_ff);
      end else begin
         x_div = XW'(cfg.target_voltage_mv) + XW'(dpcr_pkg::REG_HIGHEST_MV);
      end
   end

   assign divisor = div_end_ff ? BW'(dpcr_pkg::REG_SPAN_MV) : BW'(dpcr_pkg::START_DIV);

   always_comb begin
      unique case (cmd.mul_op)
         dpcr_pkg::MUL_ER: begin
            mul_a = AW'(vr_ff);
            mul_b = BW'(cur_ff);
         end
         dpcr_pkg::MUL_ET: begin
            mul_a = AW'(vt_ff);
            mul_b = BW'(cur_ff);
         end
         dpcr_pkg::MUL_PA: begin
            mul_a = er_ff;
            mul_b = cfg.max_power_transistor_mw;
         end
         dpcr_pkg::MUL_PB: begin
            mul_a = et_ff;
            mul_b = cfg.max_power_regulator_mw;
         end
         dpcr_pkg::MUL_Y: begin
            mul_a = AW'(x_div);
            mul_b = BW'(dpcr_pkg::PWM_TOP);
         end
         dpcr_pkg::MUL_Z: begin
            mul_a = pa_ff[AW-1:0];
            mul_b = div_end_ff ? BW'(dpcr_pkg::END_RECIP) : BW'(dpcr_pkg::START_RECIP);
         end
         dpcr_pkg::MUL_R: begin
            mul_a = AW'(quo_ff);
            mul_b = divisor;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PW'(mul_a) * PW'(mul_b);

   // remainder check after the reciprocal estimate (off by at most one)
   assign rem    = pa_ff[AW-1:0] - pb_ff[AW-1:0];
   assign fix_up = (rem >= AW'(divisor));

   // ---------------------------------------------------------------- compares
   assign reg_lim = AW'(cfg.max_power_regulator_mw) * AW'(dpcr_pkg::POWER_SCALE);
   assign tr_lim  = AW'(cfg.max_power_transistor_mw) * AW'(dpcr_pkg::POWER_SCALE);
   assign pa2     = CW'({pa_ff, 1'b0});
   assign pb2     = CW'({pb_ff, 1'b0});
   assign pa3     = CW'(pa_ff) + pa2;
   assign pb3     = CW'(pb_ff) + pb2;

   always_comb begin
      stab_c     = 1'b0;
      nudge_up_c = 1'b0;
      nudge_dn_c = 1'b0;
      if (cfg.mode == dpcr_pkg::MODE_CURRENT) begin
         stab_c = (16'(cur_ff) * 16'(10) > 16'(cfg.target_current_ma) * 16'(9)) &&
                  (16'(cur_ff) * 16'(10) < 16'(cfg.target_current_ma) * 16'(11));
         nudge_up_c = 19'(cur_ff) * 19'(100) < 19'(cfg.target_current_ma) * 19'(99);
         nudge_dn_c = 19'(cur_ff) * 19'(100) > 19'(cfg.target_current_ma) * 19'(101);
      end else if (cfg.mode == dpcr_pkg::MODE_VOLTAGE) begin
         stab_c = (19'(bat_ff) * 19'(20) > 19'(cfg.target_voltage_mv) * 19'(19)) &&
                  (19'(bat_ff) * 19'(20) < 19'(cfg.target_voltage_mv) * 19'(21));
         nudge_up_c = 24'(bat_ff) * 24'(1000) < 24'(cfg.target_voltage_mv) * 24'(996);
         nudge_dn_c = 24'(bat_ff) * 24'(1000) > 24'(cfg.target_voltage_mv) * 24'(1004);
      end
   end

   assign to_reg = stab_ff || (c3_ff != '0);

   assign preset_lvl = (quo_ff > QW'(dpcr_pkg::PWM_TOP)) ? LW'(dpcr_pkg::PWM_TOP)
                                                           : quo_ff[LW-1:0];

   always_comb begin
      if (neg_ff)
         park = (quo_ff == '0) ? LW'(1) : '0;
      else if (quo_ff >= QW'(dpcr_pkg::PWM_TOP))
         park = LW'(dpcr_pkg::PWM_TOP);
      else
         park = quo_ff[LW-1:0] + LW'(1);
   end

   // ---------------------------------------------------------------- levels
   always_comb begin
      tr_lvl_in  = tr_lvl_ff;
      reg_lvl_in = reg_lvl_ff;
      phase_in   = phase_ff;
      c10_in     = c10_ff;
      c3_in      = c3_ff;
      unique case (cmd.step)
         dpcr_pkg::STEP_PHASE: begin
            if (phase_ff >= dpcr_pkg::PHASE_W'(dpcr_pkg::LOOP_PERIOD)) begin
               phase_in = dpcr_pkg::PHASE_W'(1);
               c10_in   = dpcr_pkg::C10_W'(1 % dpcr_pkg::POWER_CHECK_EVERY);
               c3_in    = dpcr_pkg::C3_W'(1);
            end else begin
               phase_in = phase_ff + dpcr_pkg::PHASE_W'(1);
               c10_in   = (c10_ff == dpcr_pkg::C10_W'(dpcr_pkg::POWER_CHECK_EVERY - 1))
                          ? '0 : c10_ff + dpcr_pkg::C10_W'(1);
               c3_in    = (c3_ff == dpcr_pkg::C3_W'(2)) ? '0 : c3_ff + dpcr_pkg::C3_W'(1);
            end
         end
         dpcr_pkg::STEP_OVR_REG: begin
            if (er_ff > reg_lim) begin
               reg_lvl_in = sat_add(reg_lvl_ff, D_FOUR);
               tr_lvl_in  = sat_add(tr_lvl_ff, -D_FOUR);
            end
         end
         dpcr_pkg::STEP_OVR_TR: begin
            if (et_ff > tr_lim) begin
               reg_lvl_in = sat_add(reg_lvl_ff, -D_FOUR);
               tr_lvl_in  = sat_add(tr_lvl_ff, D_FOUR);
            end
         end
         dpcr_pkg::STEP_BAL_UP: begin
            if (pa2 > pb3) begin
               reg_lvl_in = sat_add(reg_lvl_ff, D_ONE);
               tr_lvl_in  = sat_add(tr_lvl_ff, -D_ONE);
            end
         end
         dpcr_pkg::STEP_BAL_DN: begin
            if (pa3 < pb2) begin
               reg_lvl_in = sat_add(reg_lvl_ff, -D_ONE);
               tr_lvl_in  = sat_add(tr_lvl_ff, D_ONE);
            end
         end
         dpcr_pkg::STEP_OVERCUR: begin
            if (cur_ff > cfg.max_current_ma)
               tr_lvl_in = sat_add(tr_lvl_ff, -D_TWO);
         end
         dpcr_pkg::STEP_HEAD: begin
            if (15'(vres_ff) + 15'(vt_ff) < 15'(cfg.min_headroom_mv))
               reg_lvl_in = sat_add(reg_lvl_ff, D_ONE);
         end
         dpcr_pkg::STEP_NUDGE_UP: begin
            if (nudge_up_c) begin
               if (to_reg)
                  reg_lvl_in = sat_add(reg_lvl_ff, D_ONE);
               else
                  tr_lvl_in = sat_add(tr_lvl_ff, D_ONE);
            end
         end
         dpcr_pkg::STEP_NUDGE_DN: begin
            if (nudge_dn_c) begin
               if (to_reg)
                  reg_lvl_in = sat_add(reg_lvl_ff, -D_ONE);
               else
                  tr_lvl_in = sat_add(tr_lvl_ff, -D_ONE);
            end
         end
         dpcr_pkg::STEP_PRESET: begin
            reg_lvl_in = preset_lvl;
            tr_lvl_in  = (dpcr_pkg::NEARLY_OPEN_LEVEL > dpcr_pkg::PWM_TOP)
                         ? LW'(dpcr_pkg::PWM_TOP) : LW'(dpcr_pkg::NEARLY_OPEN_LEVEL);
         end
         default: begin
            // hold
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_lvl_ff  <= '0;
         reg_lvl_ff <= LW'(dpcr_pkg::PWM_TOP);
         phase_ff   <= '0;
         c10_ff     <= '0;
         c3_ff      <= '0;
      end else begin
         tr_lvl_ff  <= tr_lvl_in;
         reg_lvl_ff <= reg_lvl_in;
         phase_ff   <= phase_in;
         c10_ff     <= c10_in;
         c3_ff      <= c3_in;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_ff  <= req_tdata[11:0];
         bat_ff  <= req_tdata[25:12];
         vr_ff   <= req_tdata[39:26];
         vt_ff   <= req_tdata[53:40];
         vres_ff <= req_tdata[67:54];
         stab_ff <= 1'b0;
      end else if (cmd.step == dpcr_pkg::STEP_STAB) begin
         stab_ff <= stab_c;
      end

      unique case (cmd.mul_op)
         dpcr_pkg::MUL_ER: er_ff <= prod[AW-1:0];
         dpcr_pkg::MUL_ET: et_ff <= prod[AW-1:0];
         dpcr_pkg::MUL_PA: pa_ff <= prod;
         dpcr_pkg::MUL_PB: pb_ff <= prod;
         dpcr_pkg::MUL_Y: begin
            pa_ff      <= prod;
            div_end_ff <= cmd.div_end;
            neg_ff     <= (bat_ff < MW'(dpcr_pkg::REG_REF_MV));
         end
         dpcr_pkg::MUL_Z: quo_ff <= prod[dpcr_pkg::DIV_SHIFT +: QW];
         dpcr_pkg::MUL_R: pb_ff <= prod;
         default: begin
         end
      endcase

      if (cmd.step == dpcr_pkg::STEP_FIX && fix_up)
         quo_ff <= quo_ff + QW'(1);

      if (cmd.load_out) begin
         if (cmd.out_sel == dpcr_pkg::OUT_PARK)
            rsp_data_ff <= {7'b0, 1'b0, park, 8'b0};
         else
            rsp_data_ff <= {7'b0, stab_ff, reg_lvl_ff, tr_lvl_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // balance runs when the phase about to be entered is a multiple of the check period
   assign status.bal_due = (phase_ff >= dpcr_pkg::PHASE_W'(dpcr_pkg::LOOP_PERIOD))
                           ? ((1 % dpcr_pkg::POWER_CHECK_EVERY) == 0)
                           : (c10_ff == dpcr_pkg::C10_W'(dpcr_pkg::POWER_CHECK_EVERY - 1));

   `CHK_IMPLY(a_levels_in_range, clock, reset, 1'b1, (tr_lvl_ff <= LW'(dpcr_pkg::PWM_TOP)) && (reg_lvl_ff <= LW'(dpcr_pkg::PWM_TOP)), "drive level above PWM top")
   `CHK_NEXT(a_phase_step_nonzero, clock, reset, cmd.step == dpcr_pkg::STEP_PHASE, (phase_ff != '0) && (phase_ff <= dpcr_pkg::PHASE_W'(dpcr_pkg::LOOP_PERIOD)), "phase outside its cycle after a step")

endmodule

FILE: rtl/dpcr_ctrl.sv
// ----------------------------------------------------------------------------
// dpcr_ctrl
// Sequencer for the charge regulator: accepts an item, walks the datapath
// through multiply, compare and adjust steps, and hands off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpcr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dpcr_pkg::KIND_W-1:0]    req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output dpcr_pkg::cmd_type              cmd,
   input  dpcr_pkg::status_type           status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_PHASE,
      S_MUL_ER,
      S_MUL_ET,
      S_MUL_PA,
      S_MUL_PB,
      S_OVR_REG,
      S_OVR_TR,
      S_BAL_UP,
      S_BAL_DN,
      S_OVERCUR,
      S_STAB,
      S_HEAD,
      S_NUDGE_UP,
      S_NUDGE_DN,
      S_DIV_Y,
      S_DIV_Z,
      S_DIV_R,
      S_DIV_FIX,
      S_PRESET,
      S_RESULT
   } state_type;

   state_type                       state_ff;
   state_type                       state_in;
   logic [dpcr_pkg::KIND_W-1:0]     kind_ff;
   logic                            rsp_valid_ff;
   logic                            out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  dpcr_pkg::KIND_STEP:  state_in = S_PHASE;
                  dpcr_pkg::KIND_START: state_in = S_DIV_Y;
                  dpcr_pkg::KIND_END:   state_in = S_DIV_Y;
                  default:              state_in = S_RESULT;
               endcase
            end
         end
         S_PHASE:    state_in = status.bal_due ? S_MUL_ER : S_OVERCUR;
         S_MUL_ER:   state_in = S_MUL_ET;
         S_MUL_ET:   state_in = S_MUL_PA;
         S_MUL_PA:   state_in = S_MUL_PB;
         S_MUL_PB:   state_in = S_OVR_REG;
         S_OVR_REG:  state_in = S_OVR_TR;
         S_OVR_TR:   state_in = S_BAL_UP;
         S_BAL_UP:   state_in = S_BAL_DN;
         S_BAL_DN:   state_in = S_OVERCUR;
         S_OVERCUR:  state_in = S_STAB;
         S_STAB:     state_in = S_HEAD;
         S_HEAD:     state_in = S_NUDGE_UP;
         S_NUDGE_UP: state_in = S_NUDGE_DN;
         S_NUDGE_DN: state_in = S_RESULT;
         S_DIV_Y:    state_in = S_DIV_Z;
         S_DIV_Z:    state_in = S_DIV_R;
         S_DIV_R:    state_in = S_DIV_FIX;
         S_DIV_FIX:  state_in = (kind_ff == dpcr_pkg::KIND_START) ? S_PRESET : S_RESULT;
         S_PRESET:   state_in = S_RESULT;
         S_RESULT:   state_in = out_free ? S_IDLE : S_RESULT;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = dpcr_pkg::MUL_NONE;
      cmd.step     = dpcr_pkg::STEP_NONE;
      cmd.out_sel  = (kind_ff == dpcr_pkg::KIND_END) ? dpcr_pkg::OUT_PARK
                                                     : dpcr_pkg::OUT_LEVELS;
      cmd.div_end  = (kind_ff == dpcr_pkg::KIND_END);
      unique case (state_ff)
         S_IDLE:     cmd.load_in = req_tvalid;
         S_PHASE:    cmd.step = dpcr_pkg::STEP_PHASE;
         S_MUL_ER:   cmd.mul_op = dpcr_pkg::MUL_ER;
         S_MUL_ET:   cmd.mul_op = dpcr_pkg::MUL_ET;
         S_MUL_PA:   cmd.mul_op = dpcr_pkg::MUL_PA;
         S_MUL_PB:   cmd.mul_op = dpcr_pkg::MUL_PB;
         S_OVR_REG:  cmd.step = dpcr_pkg::STEP_OVR_REG;
         S_OVR_TR:   cmd.step = dpcr_pkg::STEP_OVR_TR;
         S_BAL_UP:   cmd.step = dpcr_pkg::STEP_BAL_UP;
         S_BAL_DN:   cmd.step = dpcr_pkg::STEP_BAL_DN;
         S_OVERCUR:  cmd.step = dpcr_pkg::STEP_OVERCUR;
         S_STAB:     cmd.step = dpcr_pkg::STEP_STAB;
         S_HEAD:     cmd.step = dpcr_pkg::STEP_HEAD;
         S_NUDGE_UP: cmd.step = dpcr_pkg::STEP_NUDGE_UP;
         S_NUDGE_DN: cmd.step = dpcr_pkg::STEP_NUDGE_DN;
         S_DIV_Y:    cmd.mul_op = dpcr_pkg::MUL_Y;
         S_DIV_Z:    cmd.mul_op = dpcr_pkg::MUL_Z;
         S_DIV_R:    cmd.mul_op = dpcr_pkg::MUL_R;
         S_DIV_FIX:  cmd.step = dpcr_pkg::STEP_FIX;
         S_PRESET:   cmd.step = dpcr_pkg::STEP_PRESET;
         S_RESULT:   cmd.load_out = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= dpcr_pkg::KIND_STEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_tvalid)
            kind_ff <= req_tuser;
         if (cmd.load_out)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   `CHK_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a second item without finishing the first")
   `CHK_IMPLY(a_result_into_free_slot, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_tready, "result overwrote an untaken transfer")
   `CHK_IMPLY(a_idle_issues_nothing, clock, reset, state_ff == S_IDLE, (cmd.mul_op == dpcr_pkg::MUL_NONE) && (cmd.step == dpcr_pkg::STEP_NONE) && !cmd.load_out, "datapath command issued while idle")

endmodule

FILE: rtl/dual_pwm_charge_regulator_top.sv
// ----------------------------------------------------------------------------
// dual_pwm_charge_regulator_top
// Regulator and pass transistor PWM level controller driven by sensor items.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one sensor item per transfer; req_tuser carries the item kind
//   (control step, charging started, charging ended). rsp_* returns exactly
//   one result per item. csr_* is a register port for mode, targets, limits
//   and budgets; write it only while no item is in flight.
//   The power balance runs on every tenth control step. One item is
//   processed at a time; the sequencer walks a single shared 26x16
//   multiplier and the saturating level adjust logic, one operation per
//   cycle while no result waits on rsp_tready, which sets the rate.
//   Reset clears both drive levels to their park values (transistor 0,
//   regulator at PWM top), the phase to zero and the registers to defaults.
//   A finished result sits in an output register; the next item is accepted
//   while it waits, but its own result is held back until rsp_tready drains
//   the previous one.
// ----------------------------------------------------------------------------
module dual_pwm_charge_regulator_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: current_ma[11:0], battery_mv[25:12], regulator_drop_mv[39:26],
   //            transistor_drop_mv[53:40], resistor_drop_mv[67:54], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dpcr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: kind[1:0]
   input  logic [dpcr_pkg::KIND_W-1:0]       req_tuser,
   // rsp_tdata: transistor_pwm[7:0], regulator_pwm[15:8], stabilized[16], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dpcr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dpcr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dpcr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dpcr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   dpcr_pkg::cfg_type    cfg;
   dpcr_pkg::cmd_type    cmd;
   dpcr_pkg::status_type status;

   dpcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dpcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dpcr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
